// File: design/b2da_pkg.sv
// shared constants, types and helpers for the binary to decimal ascii converter
package b2da_pkg;

	localparam int VALUE_BITS = 32;
	localparam int IN_W       = 32;
	localparam int CHAR_W     = 6;
	localparam int RADIX      = 10;

	// decimal digits needed for the largest value of the given width
	function automatic int digits_for(input int bits);
		logic [63:0] v;
		int          n;
		v = {64{1'b1}} >> (64 - bits);
		n = 0;
		while (v != 64'd0) begin
			v = v / RADIX;
			n = n + 1;
		end
		return n;
	endfunction

	localparam int NUM_DIGITS = digits_for(VALUE_BITS);
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic skip;
		logic emit;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic top_zero;
	} status_t;

endpackage

// File: design/b2da_datapath.sv
// datapath: shift-add-3 register pair, digit alignment and output register
module b2da_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  b2da_pkg::cmd_t                       cmd,
	input  logic [b2da_pkg::IN_W-1:0]            value,
	output b2da_pkg::status_t                    status,
	output logic [b2da_pkg::CHAR_W-1:0]          digit_char,
	output logic                                 last,
	output logic                                 strobe
);

	logic [b2da_pkg::VALUE_BITS-1:0] bin_q;
	logic [b2da_pkg::BCD_W-1:0]      bcd_q;
	logic [b2da_pkg::BCD_W-1:0]      bcd_adj;
	logic [3:0]                      top_digit;
	logic [b2da_pkg::CHAR_W-1:0]     char_q;
	logic                            last_q;
	logic                            strobe_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign top_digit       = bcd_q[b2da_pkg::BCD_W-1 -: 4];
	assign status.top_zero = (top_digit == 4'd0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= b2da_pkg::VALUE_BITS'(value);
			bcd_q <= '0;
		end else if (cmd.shift) begin
			bin_q <= {bin_q[b2da_pkg::VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[b2da_pkg::BCD_W-2:0], bin_q[b2da_pkg::VALUE_BITS-1]};
		end else if (cmd.skip || cmd.emit) begin
			bcd_q <= {bcd_q[b2da_pkg::BCD_W-5:0], 4'd0};
		end
		if (cmd.emit) begin
			char_q <= b2da_pkg::ASCII_ZERO + {{(b2da_pkg::CHAR_W-4){1'b0}}, top_digit};
			last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	assign digit_char = char_q;
	assign last       = last_q;
	assign strobe     = strobe_q;

endmodule

// File: design/b2da_ctrl.sv
// controller: sequences load, conversion, leading zero skip and digit emission
module b2da_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  b2da_pkg::status_t status,
	output b2da_pkg::cmd_t    cmd,
	output logic              busy
);

	b2da_pkg::state_t                  state_q, state_d;
	logic [b2da_pkg::BIT_CNT_W-1:0]    bit_cnt_q, bit_cnt_d;
	logic [b2da_pkg::DIG_CNT_W-1:0]    dig_cnt_q, dig_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= b2da_pkg::ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			bit_cnt_q <= bit_cnt_d;
			dig_cnt_q <= dig_cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		bit_cnt_d = bit_cnt_q;
		dig_cnt_d = dig_cnt_q;
		cmd       = '0;
		busy      = 1'b1;
		unique case (state_q)
			b2da_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load  = 1'b1;
					bit_cnt_d = '0;
					state_d   = b2da_pkg::ST_CONVERT;
				end
			end
			b2da_pkg::ST_CONVERT: begin
				cmd.shift = 1'b1;
				bit_cnt_d = bit_cnt_q + 1'b1;
				if (bit_cnt_q == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_BITS - 1)) begin
					dig_cnt_d = b2da_pkg::DIG_CNT_W'(b2da_pkg::NUM_DIGITS);
					state_d   = b2da_pkg::ST_SKIP;
				end
			end
			b2da_pkg::ST_SKIP: begin
				// drop leading zeros but always keep the units digit
				if (status.top_zero && dig_cnt_q > b2da_pkg::DIG_CNT_W'(1)) begin
					cmd.skip  = 1'b1;
					dig_cnt_d = dig_cnt_q - 1'b1;
				end else begin
					state_d = b2da_pkg::ST_EMIT;
				end
			end
			b2da_pkg::ST_EMIT: begin
				cmd.emit  = 1'b1;
				cmd.last  = (dig_cnt_q == b2da_pkg::DIG_CNT_W'(1));
				dig_cnt_d = dig_cnt_q - 1'b1;
				if (cmd.last) begin
					state_d = b2da_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = b2da_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/binary_to_decimal_ascii_core.sv
// top level of the binary to decimal ascii converter
// Converts one unsigned binary value into its decimal text, one ASCII digit
// per result beat, most significant first, no leading zeros; zero gives '0'.
// Input: value is taken at a rising edge with start high and busy low; busy
// then stays high until the conversion is done.
// Output: each digit shows on digit_char for exactly one cycle with strobe
// high; last marks the units digit. The receiver cannot hold beats off.
// Sequence per value (32-bit build): the accept, one shift-add-3 step per
// value bit in the double-dabble register, one step per leading zero
// dropped, a hand-over to emission, then one digit per cycle. Digits leave on
// consecutive cycles, starting after the hand-over. Leading zeros dropped
// plus digits shown always total 10. A new value may be started in the
// cycle the last digit is shown.
// Reset clears the controller and the strobe; nothing is kept between values.
module binary_to_decimal_ascii_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [b2da_pkg::IN_W-1:0]       value,
	output logic                            strobe,
	output logic [b2da_pkg::CHAR_W-1:0]     digit_char,
	output logic                            last
);

	b2da_pkg::cmd_t    cmd;
	b2da_pkg::status_t status;

	b2da_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	b2da_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.status     (status),
		.digit_char (digit_char),
		.last       (last),
		.strobe     (strobe)
	);

endmodule

// File: design/b2da_checker.sv
// port-level checks for the converter, bound to the top level
module b2da_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            strobe,
	input logic [b2da_pkg::CHAR_W-1:0]     digit_char,
	input logic                            last
);

	// every digit beat carries an ascii decimal digit
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit_char >= b2da_pkg::ASCII_ZERO &&
			digit_char <= b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(9)))
		else $error("digit beat outside '0'..'9'");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// a run of digits has no gaps
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("gap inside a digit run");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("beat after the last digit");

	a_done_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last))
		else $error("busy dropped without a final digit");

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.digit_char (digit_char),
	.last       (last)
);
